// ===== sv/surface_crossing_region_binner_core_assert.svh =====
// Assertion macros for the surface crossing region binner core.
`ifndef SURFACE_CROSSING_REGION_BINNER_CORE_ASSERT_SVH
`define SURFACE_CROSSING_REGION_BINNER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SCRB_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scrb: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SCRB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scrb: next-cycle check failed");

`endif

// ===== sv/scrb_pkg.sv =====
// Shared types and constants of the surface crossing region binner.
package scrb_pkg;

   localparam int CELL_W        = 10;
   localparam int PACKED_LEVELS = 4;
   localparam int MASK_W        = 16;
   localparam int KIND_W        = 3;
   localparam int COUNT_W       = 3;
   localparam int SENSE_SLOTS   = 3;
   localparam int BIN_W         = 6;
   localparam int RESULT_LIMIT  = 64;
   localparam int RCNT_W        = 6;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 5;

   localparam int REQ_KIND_LSB      = 0;
   localparam int REQ_OLD_COUNT_LSB = REQ_KIND_LSB + KIND_W;
   localparam int REQ_NEW_COUNT_LSB = REQ_OLD_COUNT_LSB + COUNT_W;
   localparam int REQ_OLD_CELLS_LSB = REQ_NEW_COUNT_LSB + COUNT_W;
   localparam int REQ_NEW_CELLS_LSB = REQ_OLD_CELLS_LSB + PACKED_LEVELS * CELL_W;
   localparam int REQ_CELL_LSB      = REQ_NEW_CELLS_LSB + PACKED_LEVELS * CELL_W;
   localparam int REQ_MASK_LSB      = REQ_CELL_LSB + CELL_W;
   localparam int REQ_DATA_W        = 120;
   localparam int RSP_DATA_W        = 8;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_SCORE = 1'b1;

   localparam logic [KIND_W-1:0] KIND_NORMAL      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LEAKED      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REFLECT_OUT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REFLECT_IN  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PERIODIC    = 3'd4;

   localparam logic [1:0] SENSE_NET = 2'd0;
   localparam logic [1:0] SENSE_OUT = 2'd1;
   localparam logic [1:0] SENSE_IN  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSE_COUNT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSE_FIRST  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSE_SECOND = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSE_THIRD  = 3'd4;

   typedef enum logic [2:0] {
      LK_CLEAR,
      LK_IDLE,
      LK_LOOK,
      LK_DRAIN,
      LK_DONE
   } lk_state_type;

   typedef enum logic {
      EM_IDLE,
      EM_RUN
   } em_state_type;

   typedef struct packed {
      logic [MASK_W-1:0] old_mask;
      logic [MASK_W-1:0] new_mask;
      logic [KIND_W-1:0] kind;
   } lk_result_type;

   typedef struct packed {
      logic clearing;
      logic done;
   } lk_status_type;

   typedef struct packed {
      logic leave;
      logic enter;
   } lane_flags_type;

   typedef struct packed {
      logic [1:0]                  count;
      logic [SENSE_SLOTS-1:0][1:0] code;
   } sense_cfg_type;

endpackage

// ===== sv/scrb_lookup.sv =====
// Membership memory with clearing pass and per-level path lookup sequencer.
module scrb_lookup import scrb_pkg::*; #(
   parameter int MAX_CELLS  = 1024,
   parameter int MAX_LEVELS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            opcode,
   input  logic [KIND_W-1:0]               crossing_kind,
   input  logic [COUNT_W-1:0]              old_level_count,
   input  logic [COUNT_W-1:0]              new_level_count,
   input  logic [PACKED_LEVELS*CELL_W-1:0] old_cells,
   input  logic [PACKED_LEVELS*CELL_W-1:0] new_cells,
   input  logic [CELL_W-1:0]               table_cell,
   input  logic [MASK_W-1:0]               table_mask,
   input  logic                            take,
   output lk_result_type                   result,
   output lk_status_type                   status
);

   localparam int DEPTH = MAX_CELLS < (1 << CELL_W) ? MAX_CELLS : (1 << CELL_W);
   localparam int AW    = $clog2(DEPTH);
   localparam int LIM   = MAX_LEVELS < PACKED_LEVELS ? MAX_LEVELS : PACKED_LEVELS;
   localparam int LVW   = LIM > 1 ? $clog2(LIM) : 1;
   localparam logic [16:0] CELL_LIMIT = 17'(MAX_CELLS);

   function automatic logic in_range(input logic [CELL_W-1:0] idx);
      return 17'(idx) < CELL_LIMIT;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_levels(input logic [COUNT_W-1:0] n);
      logic [COUNT_W-1:0] lim;
      lim = COUNT_W'(LIM);
      return n > lim ? lim : n;
   endfunction

   lk_state_type state_ff, state_in;
   logic [AW-1:0]                   clr_ff, clr_in;
   logic [LVW-1:0]                  lvl_ff, lvl_in;
   logic [KIND_W-1:0]               kind_ff;
   logic [COUNT_W-1:0]              old_lim_ff, new_lim_ff;
   logic [PACKED_LEVELS*CELL_W-1:0] old_cells_ff, new_cells_ff;
   logic [MASK_W-1:0]               old_mask_ff, old_mask_in, new_mask_ff, new_mask_in;
   logic                            rd_old_vld_ff, rd_old_vld_in;
   logic                            rd_new_vld_ff, rd_new_vld_in;
   logic [MASK_W-1:0]               rd_old_ff, rd_new_ff;
   logic [MASK_W-1:0]               member_ff [DEPTH];

   logic              accept_score;
   logic              we;
   logic [AW-1:0]     waddr;
   logic [MASK_W-1:0] wdata;
   logic [CELL_W-1:0] old_cell, new_cell;

   assign old_cell = old_cells_ff[CELL_W*lvl_ff +: CELL_W];
   assign new_cell = new_cells_ff[CELL_W*lvl_ff +: CELL_W];
   assign accept_score = (state_ff == LK_IDLE) && req_valid && (opcode == OP_SCORE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LK_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) state_in = LK_IDLE;
         end
         LK_IDLE: begin
            if (accept_score) state_in = LK_LOOK;
         end
         LK_LOOK: begin
            if (lvl_ff == LVW'(LIM - 1)) state_in = LK_DRAIN;
         end
         LK_DRAIN: state_in = LK_DONE;
         LK_DONE: begin
            if (take) state_in = LK_IDLE;
         end
         default: state_in = LK_CLEAR;
      endcase
   end

   always_comb begin
      req_ready       = (state_ff == LK_IDLE);
      status.clearing = (state_ff == LK_CLEAR);
      status.done     = (state_ff == LK_DONE);
      we              = 1'b0;
      waddr           = table_cell[AW-1:0];
      wdata           = table_mask;
      unique case (state_ff)
         LK_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff;
            wdata = '0;
         end
         LK_IDLE: begin
            we = req_valid && (opcode == OP_LOAD) && in_range(table_cell);
         end
         default: we = 1'b0;
      endcase
   end

   always_comb begin
      clr_in        = (state_ff == LK_CLEAR) ? AW'(clr_ff + 1'b1) : clr_ff;
      lvl_in        = accept_score ? '0
                    : (state_ff == LK_LOOK) ? LVW'(lvl_ff + 1'b1) : lvl_ff;
      rd_old_vld_in = (state_ff == LK_LOOK) && (COUNT_W'(lvl_ff) < old_lim_ff)
                      && in_range(old_cell);
      rd_new_vld_in = (state_ff == LK_LOOK) && (COUNT_W'(lvl_ff) < new_lim_ff)
                      && in_range(new_cell);
      old_mask_in   = accept_score ? '0
                    : old_mask_ff | (rd_old_vld_ff ? rd_old_ff : '0);
      new_mask_in   = accept_score ? '0
                    : new_mask_ff | (rd_new_vld_ff ? rd_new_ff : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= LK_CLEAR;
         clr_ff        <= '0;
         rd_old_vld_ff <= 1'b0;
         rd_new_vld_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rd_old_vld_ff <= rd_old_vld_in;
         rd_new_vld_ff <= rd_new_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_score) begin
         kind_ff      <= crossing_kind;
         old_lim_ff   <= sat_levels(old_level_count);
         new_lim_ff   <= sat_levels(new_level_count);
         old_cells_ff <= old_cells;
         new_cells_ff <= new_cells;
      end
      lvl_ff      <= lvl_in;
      old_mask_ff <= old_mask_in;
      new_mask_ff <= new_mask_in;
   end

   always_ff @(posedge clock) begin
      if (we) member_ff[waddr] <= wdata;
      rd_old_ff <= member_ff[old_cell[AW-1:0]];
      rd_new_ff <= member_ff[new_cell[AW-1:0]];
   end

   assign result = '{old_mask: old_mask_ff, new_mask: new_mask_ff, kind: kind_ff};

endmodule

// ===== sv/scrb_lane.sv =====
// One region lane: boundary overrides and leave/enter decision.
module scrb_lane import scrb_pkg::*; (
   input  logic              enable,
   input  logic              from_in,
   input  logic              to_in,
   input  logic [KIND_W-1:0] crossing_kind,
   output lane_flags_type    flags
);

   logic from_eff;
   logic to_eff;
   logic both;

   always_comb begin
      from_eff = from_in;
      to_eff   = to_in;
      both     = 1'b0;
      priority if (crossing_kind == KIND_LEAKED || crossing_kind == KIND_REFLECT_OUT) begin
         to_eff = 1'b0;
      end else if (crossing_kind == KIND_REFLECT_IN) begin
         from_eff = 1'b0;
      end else if (crossing_kind == KIND_PERIODIC && from_in && to_in) begin
         both = 1'b1;
      end else begin
         both = 1'b0;
      end
      flags.leave = enable && (both || (from_eff && !to_eff));
      flags.enter = enable && (both || (!from_eff && to_eff));
   end

endmodule

// ===== sv/scrb_emit.sv =====
// Merge stage: walks lane flags and senses, one result item per cycle while the rsp register is free or taken.
module scrb_emit import scrb_pkg::*; #(
   parameter int MAX_REGIONS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    ready,
   input  lane_flags_type [MAX_REGIONS-1:0]        flags,
   input  sense_cfg_type                           sense_cfg,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [RSP_DATA_W-1:0]                   rsp_tdata,
   output logic                                    rsp_tlast
);

   localparam int PN = 2 * MAX_REGIONS;
   localparam int PW = $clog2(PN);
   localparam logic [PN-1:0] ONE_PN = PN'(1);

   em_state_type state_ff, state_in;
   logic [PN-1:0]          pending_ff, pending_in;
   logic [SENSE_SLOTS-1:0] sdone_ff, sdone_in;
   logic [RCNT_W-1:0]      cnt_ff, cnt_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic                   rsp_tlast_ff, rsp_tlast_in;

   logic [SENSE_SLOTS-1:0] leave_mask, enter_mask, pmask, rem, rem_next, s_hot;
   logic [PN-1:0]          pend_new, pend_clr;
   logic [PW-1:0]          cur;
   logic [1:0]             s;
   logic                   phase_enter, last_pair, last, fire, neg;
   logic [BIN_W-1:0]       bin;

   always_comb begin
      for (int k = 0; k < SENSE_SLOTS; k++) begin
         leave_mask[k] = (2'(k) < sense_cfg.count)
                         && (sense_cfg.code[k] == SENSE_NET || sense_cfg.code[k] == SENSE_OUT);
         enter_mask[k] = (2'(k) < sense_cfg.count)
                         && (sense_cfg.code[k] == SENSE_NET || sense_cfg.code[k] == SENSE_IN);
      end
      for (int r = 0; r < MAX_REGIONS; r++) begin
         pend_new[2*r]   = flags[r].leave && (|leave_mask);
         pend_new[2*r+1] = flags[r].enter && (|enter_mask);
      end
   end

   always_comb begin
      cur = '0;
      for (int i = PN - 1; i >= 0; i--) begin
         if (pending_ff[i]) cur = PW'(i);
      end
      phase_enter = cur[0];
      pmask       = phase_enter ? enter_mask : leave_mask;
      rem         = pmask & ~sdone_ff;
      priority if (rem[0]) begin
         s = 2'd0;
      end else if (rem[1]) begin
         s = 2'd1;
      end else begin
         s = 2'd2;
      end
      s_hot     = SENSE_SLOTS'(1) << s;
      rem_next  = rem & ~s_hot;
      pend_clr  = pending_ff & ~(ONE_PN << cur);
      last_pair = (rem_next == '0);
      last      = (last_pair && (pend_clr == '0)) || (cnt_ff == RCNT_W'(RESULT_LIMIT - 1));
      neg       = (sense_cfg.code[s] == SENSE_NET) && phase_enter;
      bin       = BIN_W'(cur >> 1) * BIN_W'(sense_cfg.count) + BIN_W'(s);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EM_IDLE: begin
            if (start && (pend_new != '0)) state_in = EM_RUN;
         end
         EM_RUN: begin
            if (fire && last) state_in = EM_IDLE;
         end
         default: state_in = EM_IDLE;
      endcase
   end

   always_comb begin
      ready = (state_ff == EM_IDLE);
      fire  = (state_ff == EM_RUN) && (!rsp_tvalid_ff || rsp_tready);
   end

   always_comb begin
      pending_in    = pending_ff;
      sdone_in      = sdone_ff;
      cnt_in        = cnt_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      rsp_tvalid_in = rsp_tready ? 1'b0 : rsp_tvalid_ff;
      if (state_ff == EM_IDLE && start) begin
         pending_in = pend_new;
         sdone_in   = '0;
         cnt_in     = '0;
      end else if (fire) begin
         cnt_in        = RCNT_W'(cnt_ff + 1'b1);
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {1'b0, neg, bin};
         rsp_tlast_in  = last;
         if (last_pair) begin
            pending_in = pend_clr;
            sdone_in   = '0;
         end else begin
            sdone_in = sdone_ff | s_hot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= EM_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_ff   <= pending_in;
      sdone_ff     <= sdone_in;
      cnt_ff       <= cnt_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

// ===== sv/surface_crossing_region_binner_core.sv =====
// Top level of the surface crossing region binner.
//
// req channel: one item per handshake; req_tuser low loads a membership entry, high
// scores a crossing. A load gives no result item.
// A crossing reads the membership memory for one path level of each side per cycle
// over LIM = min(MAX_LEVELS, 4) levels, then drains and hands both region masks
// to the region lanes; the next item is taken once the merge stage is ready.
// The merge stage then puts out one result item per cycle while the rsp register is
// free or rsp_tready is high. rsp_tlast marks the last result of a crossing; at
// most 64 results leave per crossing.
// When rsp_tready is low and a result is waiting, the result register holds and
// the merge stage waits; the lookup side finishes its current item and then waits
// for the merge stage.
// After reset all min(MAX_CELLS, 1024) memory entries are swept to zero, during which
// req_tready stays low; csr writes are taken at any time (csr_ready is always high).
`include "surface_crossing_region_binner_core_assert.svh"

module surface_crossing_region_binner_core import scrb_pkg::*; #(
   parameter int MAX_REGIONS = 16,
   parameter int MAX_CELLS   = 1024,
   parameter int MAX_LEVELS  = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // crossing_kind, old_level_count, new_level_count, old_cells, new_cells,
   // table_cell, table_mask, zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // opcode
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // bin_index, negative_weight, zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [4:0] region_count_ff;
   logic [1:0] sense_count_ff, sense_first_ff, sense_second_ff, sense_third_ff;

   lk_result_type                    lk_result;
   lk_status_type                    lk_status;
   lane_flags_type [MAX_REGIONS-1:0] lane_flags;
   sense_cfg_type                    sense_cfg;
   logic                             em_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_count_ff <= 5'd1;
         sense_count_ff  <= 2'd1;
         sense_first_ff  <= SENSE_NET;
         sense_second_ff <= SENSE_OUT;
         sense_third_ff  <= SENSE_IN;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REGION_COUNT: region_count_ff <= csr_data;
            CSR_SENSE_COUNT:  sense_count_ff  <= csr_data[1:0];
            CSR_SENSE_FIRST:  sense_first_ff  <= csr_data[1:0];
            CSR_SENSE_SECOND: sense_second_ff <= csr_data[1:0];
            CSR_SENSE_THIRD:  sense_third_ff  <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   assign sense_cfg.count   = sense_count_ff;
   assign sense_cfg.code[0] = sense_first_ff;
   assign sense_cfg.code[1] = sense_second_ff;
   assign sense_cfg.code[2] = sense_third_ff;

   scrb_lookup #(
      .MAX_CELLS  (MAX_CELLS),
      .MAX_LEVELS (MAX_LEVELS)
   ) u_lookup (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .opcode          (req_tuser),
      .crossing_kind   (req_tdata[REQ_KIND_LSB +: KIND_W]),
      .old_level_count (req_tdata[REQ_OLD_COUNT_LSB +: COUNT_W]),
      .new_level_count (req_tdata[REQ_NEW_COUNT_LSB +: COUNT_W]),
      .old_cells       (req_tdata[REQ_OLD_CELLS_LSB +: PACKED_LEVELS*CELL_W]),
      .new_cells       (req_tdata[REQ_NEW_CELLS_LSB +: PACKED_LEVELS*CELL_W]),
      .table_cell      (req_tdata[REQ_CELL_LSB +: CELL_W]),
      .table_mask      (req_tdata[REQ_MASK_LSB +: MASK_W]),
      .take            (em_ready),
      .result          (lk_result),
      .status          (lk_status)
   );

   for (genvar r = 0; r < MAX_REGIONS; r++) begin : g_lane
      scrb_lane u_lane (
         .enable        (5'(r) < region_count_ff),
         .from_in       (lk_result.old_mask[r]),
         .to_in         (lk_result.new_mask[r]),
         .crossing_kind (lk_result.kind),
         .flags         (lane_flags[r])
      );
   end

   scrb_emit #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (lk_status.done),
      .ready      (em_ready),
      .flags      (lane_flags),
      .sense_cfg  (sense_cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `SCRB_ASSERT_IMPLY(a_no_accept_while_clearing, clock, reset, lk_status.clearing, !req_tready)
   `SCRB_ASSERT_NEXT(a_handoff_single, clock, reset, lk_status.done && em_ready, !lk_status.done)
   `SCRB_ASSERT_IMPLY(a_bin_in_range, clock, reset, rsp_tvalid, rsp_tdata[5:0] < 6'd48)

endmodule
